@@ hdl/mcoc_pkg.sv @@
// ============================================================================
// mcoc_pkg
// Shared widths, codes and controller/datapath interface types for the
// mip chain offset calculator.
// ============================================================================
package mcoc_pkg;

  // Field and register widths.
  localparam int TEX_DIM_W   = 13;
  localparam int TEX_DEPTH_W = 12;
  localparam int MIP_CNT_W   = 4;
  localparam int BLK_W_W     = 4;
  localparam int MIN_BLK_W   = 3;
  localparam int ELEM_W      = 5;
  localparam int MIP_IN_W    = 5;
  localparam int SLICE_W     = 12;
  localparam int OFFSET_W    = 40;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  // Defaults for the top-level parameters.
  localparam int MAX_MIP_LEVELS_DEF = 13;
  localparam int MAX_DIM_BITS_DEF   = 12;

  // Format and layout constants.
  localparam int CUBE_FACES      = 6;
  localparam int ROW_BLOCK_SHIFT = 2;

  // Shared arithmetic units.
  localparam int DIV_W     = TEX_DIM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 13;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int LVL_W     = 31;
  localparam int HALF_W    = OFFSET_W / 2;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH     = 3'd0,
    CFG_TEX_HEIGHT    = 3'd1,
    CFG_TEX_DEPTH     = 3'd2,
    CFG_CUBE_MAP      = 3'd3,
    CFG_MIP_LEVELS    = 3'd4,
    CFG_BLOCK_WIDTH   = 3'd5,
    CFG_MIN_BLOCKS    = 3'd6,
    CFG_ELEMENT_BYTES = 3'd7
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_MIXED = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_MUL_XY,
    OP_MUL_EB,
    OP_MUL_D,
    OP_ACC_LVL,
    OP_MUL_LT,
    OP_MUL_LF,
    OP_MUL_FLO,
    OP_MUL_FHI,
    OP_ADD_T,
    OP_ADD_F,
    OP_ADD_T_HI
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic mixed;
    logic compressed;
    logic lvl_last;
    logic need_lt;
    logic need_lf;
    logic need_face;
  } stat_t;

endpackage

@@ hdl/mcoc_ctrl.sv @@
// ============================================================================
// mcoc_ctrl
// Sequencer that walks the mip levels and the final terms, and owns the
// handshake state of both channels.
// ============================================================================
module mcoc_ctrl
  import mcoc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_LVL, S_DIV, S_XY, S_EB, S_D, S_ACC,
    S_MLT, S_ALT, S_MLF, S_ALF, S_MFL, S_AFL, S_MFH, S_AFH, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.load      = 1'b0;
    cmd.emit      = 1'b0;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.mixed ? S_DONE : S_LVL;
      end
      S_LVL: begin
        if (stat.compressed) begin
          cmd.op    = OP_DIV_START;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cmd.op    = OP_MUL_XY;
          state_nxt = S_EB;
        end
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          state_nxt = S_XY;
        end
      end
      S_XY: begin
        cmd.op    = OP_MUL_XY;
        state_nxt = S_EB;
      end
      S_EB: begin
        cmd.op    = OP_MUL_EB;
        state_nxt = S_D;
      end
      S_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC_LVL;
        if (!stat.lvl_last) begin
          state_nxt = S_LVL;
        end else if (stat.need_lt) begin
          state_nxt = S_MLT;
        end else if (stat.need_face) begin
          state_nxt = S_MFL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MLT: begin
        cmd.op    = OP_MUL_LT;
        state_nxt = S_ALT;
      end
      S_ALT: begin
        cmd.op = OP_ADD_T;
        if (stat.need_lf) begin
          state_nxt = S_MLF;
        end else if (stat.need_face) begin
          state_nxt = S_MFL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MLF: begin
        cmd.op    = OP_MUL_LF;
        state_nxt = S_ALF;
      end
      S_ALF: begin
        cmd.op    = OP_ADD_F;
        state_nxt = S_MFL;
      end
      S_MFL: begin
        cmd.op    = OP_MUL_FLO;
        state_nxt = S_AFL;
      end
      S_AFL: begin
        cmd.op    = OP_ADD_T;
        state_nxt = S_MFH;
      end
      S_MFH: begin
        cmd.op    = OP_MUL_FHI;
        state_nxt = S_AFH;
      end
      S_AFH: begin
        cmd.op    = OP_ADD_T_HI;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/mcoc_dp.sv @@
// ============================================================================
// mcoc_dp
// Datapath: configuration registers, level geometry, a restoring divider,
// one shared multiplier and two saturating 40-bit accumulators.
// ============================================================================
module mcoc_dp
  import mcoc_pkg::*;
#(
  parameter int MAX_MIP_LEVELS = MAX_MIP_LEVELS_DEF,
  parameter int MAX_DIM_BITS   = MAX_DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [MIP_IN_W-1:0] in_target_mip,
  input  logic signed [SLICE_W-1:0]  in_target_slice,
  output logic [OFFSET_W-1:0]   out_byte_offset,
  output logic [STATUS_W-1:0]   out_status,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  localparam int MIP_W   = $clog2(MAX_MIP_LEVELS + 1);
  localparam int DIM_LIM = 1 << MAX_DIM_BITS;

  // Configuration registers.
  logic [TEX_DIM_W-1:0]   tex_width_r, tex_height_r;
  logic [TEX_DEPTH_W-1:0] tex_depth_r;
  logic                   cube_map_r;
  logic [MIP_CNT_W-1:0]   mip_levels_r;
  logic [BLK_W_W-1:0]     block_width_r;
  logic [MIN_BLK_W-1:0]   min_blocks_r;
  logic [ELEM_W-1:0]      element_bytes_r;

  // Per-item registers.
  logic [MIP_W-1:0]    m_r, m_nxt, tm_r, tm_nxt, last_r, last_nxt;
  logic [SLICE_W-1:0]  ts_r, ts_nxt;
  logic [MUL_B_W-1:0]  k_r, k_nxt;
  logic                mixed_r, mixed_nxt, whole_r, whole_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [BLK_W_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [LVL_W-1:0]    lt_r, lt_nxt, lf_r, lf_nxt;
  logic [OFFSET_W-1:0] sum_t_r, sum_t_nxt, sum_f_r, sum_f_nxt;
  logic                sum_t_sat_r, sum_t_sat_nxt, sum_f_sat_r, sum_f_sat_nxt;
  logic [OFFSET_W-1:0] out_byte_offset_r, out_byte_offset_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Geometry of the level held in m_r.
  logic [TEX_DIM_W-1:0]   w_clamp, h_clamp, w_m, h_m, bx_c, by_c;
  logic [TEX_DEPTH_W-1:0] depth_eff, d_m;
  logic [MIP_W-1:0]       mips_c, tm_c;
  logic                   deep, compressed;

  // Divider step.
  logic [BLK_W_W:0]       rem_t;

  // Shared multiplier.
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      mul_p;

  // Saturating adder.
  logic [OFFSET_W-1:0]    add_term;
  logic                   add_over;

  function automatic logic [OFFSET_W:0] sat_add(input logic [OFFSET_W-1:0] acc,
                                                input logic                acc_sat,
                                                input logic [OFFSET_W-1:0] term,
                                                input logic                over);
    logic [OFFSET_W:0] sum;
    logic              sat;
    sum = {1'b0, acc} + {1'b0, term};
    sat = acc_sat | over | sum[OFFSET_W];
    return sat ? {1'b1, OFFSET_MAX} : {1'b0, sum[OFFSET_W-1:0]};
  endfunction

  always_comb begin
    w_clamp = ({4'b0, tex_width_r} > 17'(DIM_LIM)) ? TEX_DIM_W'(DIM_LIM) : tex_width_r;
    h_clamp = ({4'b0, tex_height_r} > 17'(DIM_LIM)) ? TEX_DIM_W'(DIM_LIM) : tex_height_r;
    w_m     = w_clamp >> m_r;
    h_m     = h_clamp >> m_r;
    if (w_m == '0) w_m = TEX_DIM_W'(1);
    if (h_m == '0) h_m = TEX_DIM_W'(1);
    by_c = h_m >> ROW_BLOCK_SHIFT;
    if (by_c < TEX_DIM_W'(min_blocks_r)) by_c = TEX_DIM_W'(min_blocks_r);
    bx_c = (quo_r < TEX_DIM_W'(min_blocks_r)) ? TEX_DIM_W'(min_blocks_r) : quo_r;
    depth_eff = (tex_depth_r == '0) ? TEX_DEPTH_W'(1) : tex_depth_r;
    d_m       = depth_eff >> m_r;
    if (d_m == '0) d_m = TEX_DEPTH_W'(1);
    deep       = (depth_eff > TEX_DEPTH_W'(1));
    compressed = (block_width_r != '0);
    mips_c = ({1'b0, mip_levels_r} > 5'(MAX_MIP_LEVELS)) ?
             MIP_W'(MAX_MIP_LEVELS) : MIP_W'(mip_levels_r);
    // Only a non-negative target mip is used, so it is compared as unsigned.
    tm_c   = ({1'b0, in_target_mip} > 6'(MAX_MIP_LEVELS)) ?
             MIP_W'(MAX_MIP_LEVELS) : MIP_W'(in_target_mip);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_XY: begin
        mul_a = compressed ? MUL_A_W'(bx_c) : MUL_A_W'(w_m);
        mul_b = compressed ? MUL_B_W'(by_c) : MUL_B_W'(h_m);
      end
      OP_MUL_EB: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(element_bytes_r);
      end
      OP_MUL_D: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(d_m);
      end
      OP_MUL_LT: begin
        mul_a = MUL_A_W'(lt_r);
        mul_b = MUL_B_W'(ts_r);
      end
      OP_MUL_LF: begin
        mul_a = MUL_A_W'(lf_r);
        mul_b = MUL_B_W'(ts_r);
      end
      OP_MUL_FLO: begin
        mul_a = MUL_A_W'(sum_f_r[HALF_W-1:0]);
        mul_b = k_r;
      end
      OP_MUL_FHI: begin
        mul_a = MUL_A_W'(sum_f_r[OFFSET_W-1:HALF_W]);
        mul_b = k_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Accumulator term: plain product, or the upper-half product moved up.
  always_comb begin
    if (cmd.op == OP_ADD_T_HI) begin
      add_term = {prod_r[OFFSET_W-HALF_W-1:0], HALF_W'(0)};
      add_over = (|prod_r[PROD_W-1:OFFSET_W-HALF_W]) | (sum_f_sat_r & (k_r != '0));
    end else begin
      add_term = prod_r[OFFSET_W-1:0];
      add_over = |prod_r[PROD_W-1:OFFSET_W];
    end
  end

  always_comb begin
    m_nxt               = m_r;
    tm_nxt              = tm_r;
    last_nxt            = last_r;
    ts_nxt              = ts_r;
    k_nxt               = k_r;
    mixed_nxt           = mixed_r;
    whole_nxt           = whole_r;
    quo_nxt             = quo_r;
    rem_nxt             = rem_r;
    prod_nxt            = prod_r;
    lt_nxt              = lt_r;
    lf_nxt              = lf_r;
    sum_t_nxt           = sum_t_r;
    sum_t_sat_nxt       = sum_t_sat_r;
    sum_f_nxt           = sum_f_r;
    sum_f_sat_nxt       = sum_f_sat_r;
    out_byte_offset_nxt = out_byte_offset_r;
    out_status_nxt      = out_status_r;
    rem_t               = {rem_r, quo_r[DIV_W-1]};

    if (cmd.load) begin
      mixed_nxt     = in_target_mip[MIP_IN_W-1] ^ in_target_slice[SLICE_W-1];
      whole_nxt     = in_target_mip[MIP_IN_W-1] & in_target_slice[SLICE_W-1];
      ts_nxt        = in_target_slice;
      m_nxt         = '0;
      sum_t_nxt     = '0;
      sum_t_sat_nxt = 1'b0;
      sum_f_nxt     = '0;
      sum_f_sat_nxt = 1'b0;
      if (whole_nxt) begin
        // Only the full chain is needed, scaled by the face count.
        tm_nxt   = '0;
        last_nxt = mips_c;
        k_nxt    = cube_map_r ? MUL_B_W'(CUBE_FACES) : MUL_B_W'(1);
      end else begin
        tm_nxt   = tm_c;
        last_nxt = (cube_map_r && (mips_c > tm_c)) ? mips_c : tm_c;
        k_nxt    = MUL_B_W'(in_target_slice);
      end
    end

    case (cmd.op)
      OP_DIV_START: begin
        quo_nxt = w_m;
        rem_nxt = '0;
      end
      OP_DIV_STEP: begin
        if (rem_t >= {1'b0, block_width_r}) begin
          rem_nxt = BLK_W_W'(rem_t - {1'b0, block_width_r});
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_t[BLK_W_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
      end
      OP_MUL_XY, OP_MUL_EB, OP_MUL_LT, OP_MUL_LF, OP_MUL_FLO, OP_MUL_FHI: begin
        prod_nxt = mul_p;
      end
      OP_MUL_D: begin
        // prod_r still holds this level's size.
        prod_nxt = mul_p;
        if (m_r == tm_r) lt_nxt = prod_r[LVL_W-1:0];
        if (m_r == mips_c) lf_nxt = prod_r[LVL_W-1:0];
      end
      OP_ACC_LVL: begin
        if (m_r < tm_r) begin
          {sum_t_sat_nxt, sum_t_nxt} = sat_add(sum_t_r, sum_t_sat_r, add_term, add_over);
        end
        if (m_r < mips_c) begin
          {sum_f_sat_nxt, sum_f_nxt} = sat_add(sum_f_r, sum_f_sat_r, add_term, add_over);
        end
        m_nxt = m_r + 1'b1;
      end
      OP_ADD_T, OP_ADD_T_HI: begin
        {sum_t_sat_nxt, sum_t_nxt} = sat_add(sum_t_r, sum_t_sat_r, add_term, add_over);
      end
      OP_ADD_F: begin
        {sum_f_sat_nxt, sum_f_nxt} = sat_add(sum_f_r, sum_f_sat_r, add_term, add_over);
      end
      default: begin
        prod_nxt = prod_r;
      end
    endcase

    if (cmd.emit) begin
      if (mixed_r) begin
        out_byte_offset_nxt = '0;
        out_status_nxt      = ST_MIXED;
      end else begin
        out_byte_offset_nxt = sum_t_r;
        out_status_nxt      = sum_t_sat_r ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r     <= '0;
      tex_height_r    <= '0;
      tex_depth_r     <= TEX_DEPTH_W'(1);
      cube_map_r      <= 1'b0;
      mip_levels_r    <= MIP_CNT_W'(1);
      block_width_r   <= '0;
      min_blocks_r    <= MIN_BLK_W'(1);
      element_bytes_r <= ELEM_W'(4);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEX_WIDTH:     tex_width_r     <= cfg_data[TEX_DIM_W-1:0];
        CFG_TEX_HEIGHT:    tex_height_r    <= cfg_data[TEX_DIM_W-1:0];
        CFG_TEX_DEPTH:     tex_depth_r     <= cfg_data[TEX_DEPTH_W-1:0];
        CFG_CUBE_MAP:      cube_map_r      <= cfg_data[0];
        CFG_MIP_LEVELS:    mip_levels_r    <= cfg_data[MIP_CNT_W-1:0];
        CFG_BLOCK_WIDTH:   block_width_r   <= cfg_data[BLK_W_W-1:0];
        CFG_MIN_BLOCKS:    min_blocks_r    <= cfg_data[MIN_BLK_W-1:0];
        CFG_ELEMENT_BYTES: element_bytes_r <= cfg_data[ELEM_W-1:0];
        default: begin
          tex_width_r <= tex_width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    m_r               <= m_nxt;
    tm_r              <= tm_nxt;
    last_r            <= last_nxt;
    ts_r              <= ts_nxt;
    k_r               <= k_nxt;
    mixed_r           <= mixed_nxt;
    whole_r           <= whole_nxt;
    quo_r             <= quo_nxt;
    rem_r             <= rem_nxt;
    prod_r            <= prod_nxt;
    lt_r              <= lt_nxt;
    lf_r              <= lf_nxt;
    sum_t_r           <= sum_t_nxt;
    sum_t_sat_r       <= sum_t_sat_nxt;
    sum_f_r           <= sum_f_nxt;
    sum_f_sat_r       <= sum_f_sat_nxt;
    out_byte_offset_r <= out_byte_offset_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign out_byte_offset = out_byte_offset_r;
  assign out_status      = out_status_r;

  assign stat.mixed      = mixed_r;
  assign stat.compressed = compressed;
  assign stat.lvl_last   = (m_r == last_r);
  assign stat.need_lt    = ~whole_r & deep;
  assign stat.need_lf    = ~whole_r & deep & cube_map_r;
  assign stat.need_face  = whole_r | cube_map_r;

endmodule

@@ hdl/mip_chain_offset_calc.sv @@
// ============================================================================
// mip_chain_offset_calc
// Byte offset of one mip level and slice or face inside a packed texture,
// or the size of the whole chain.
// ============================================================================
// Each request transfer gives one result transfer. A request is handled one
// at a time: the sequencer walks mip levels 0 through L, where L is the target
// mip (or the larger of the target mip and the mip count for a cube map, or
// the mip count for a whole-size request). Each level uses the shared
// multiplier, and when a block width is set the 13-step restoring divider for
// the block count runs first. After the walk the slice and face terms are
// added. A request with exactly one negative target skips the walk and is
// answered with status 1. A finished result sits in an output register, and
// the next request is accepted while it waits to be taken. Sums above
// 2^40-1 return 2^40-1 with status 2. Configuration is written through
// cfg_we/cfg_index/cfg_data and must only change while idle.
// ============================================================================
module mip_chain_offset_calc
  import mcoc_pkg::*;
#(
  parameter int MAX_MIP_LEVELS = MAX_MIP_LEVELS_DEF,
  parameter int MAX_DIM_BITS   = MAX_DIM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  // Request channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [MIP_IN_W-1:0] in_target_mip,
  input  logic signed [SLICE_W-1:0]  in_target_slice,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OFFSET_W-1:0]        out_byte_offset,
  output logic [STATUS_W-1:0]        out_status
);

  // Commands flow from the sequencer to the datapath; status flows back.
  cmd_t  cmd;
  stat_t stat;

  mcoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath captures the request on the load command and drives the
  // result register on the emit command.
  mcoc_dp #(
    .MAX_MIP_LEVELS (MAX_MIP_LEVELS),
    .MAX_DIM_BITS   (MAX_DIM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_target_mip   (in_target_mip),
    .in_target_slice (in_target_slice),
    .out_byte_offset (out_byte_offset),
    .out_status      (out_status),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

@@ tb/sv/mcoc_offset_checker.sv @@
// ----------------------------------------------------------------------------
// mcoc_offset_checker
// Watches the configuration port and both handshake channels of the mip chain
// offset calculator. Each request transfer is turned into the expected byte
// offset and status, and each result transfer is compared with the oldest
// expectation still waiting.
// ----------------------------------------------------------------------------
module mcoc_offset_checker
  import mcoc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [MIP_IN_W-1:0] in_target_mip,
  input  logic signed [SLICE_W-1:0]  in_target_slice,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [OFFSET_W-1:0]        out_byte_offset,
  input  logic [STATUS_W-1:0]        out_status,
  output int                         mismatch_count,
  output int                         pending_count
);

  localparam logic [63:0] DIM_LIMIT    = 64'd1 << MAX_DIM_BITS_DEF;
  localparam logic [63:0] OFFSET_LIMIT = 64'(OFFSET_MAX);
  localparam int          REPORT_MAX   = 10;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    status_t             status;
  } offset_result_t;

  // Local copy of the texture shape and format registers.
  logic [TEX_DIM_W-1:0]   tex_w;
  logic [TEX_DIM_W-1:0]   tex_h;
  logic [TEX_DEPTH_W-1:0] tex_d;
  logic                   cube;
  logic [MIP_CNT_W-1:0]   mip_cnt;
  logic [BLK_W_W-1:0]     blk_w;
  logic [MIN_BLK_W-1:0]   min_blk;
  logic [ELEM_W-1:0]      elem_b;

  offset_result_t expected_offsets[$];
  int             fail_cnt = 0;

  // Depth of a level; a zero base depth counts as one.
  function automatic logic [63:0] depth_at(int unsigned lvl);
    logic [63:0] d;
    d = (tex_d == '0) ? 64'd1 : 64'(tex_d);
    d = d >> lvl;
    return (d == 64'd0) ? 64'd1 : d;
  endfunction

  // Bytes in one slice of level lvl.
  function automatic logic [63:0] level_bytes(int unsigned lvl);
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] bx;
    logic [63:0] by;
    logic [63:0] bytes;
    w = (64'(tex_w) > DIM_LIMIT) ? DIM_LIMIT : 64'(tex_w);
    h = (64'(tex_h) > DIM_LIMIT) ? DIM_LIMIT : 64'(tex_h);
    w = w >> lvl;
    h = h >> lvl;
    if (w == 64'd0) w = 64'd1;
    if (h == 64'd0) h = 64'd1;
    if (blk_w == '0) begin
      bytes = w * h * 64'(elem_b);
    end else begin
      by = h >> ROW_BLOCK_SHIFT;
      if (by < 64'(min_blk)) by = 64'(min_blk);
      bx = w / 64'(blk_w);
      if (bx < 64'(min_blk)) bx = 64'(min_blk);
      bytes = bx * by * 64'(elem_b);
    end
    return bytes;
  endfunction

  // Bytes in levels 0 .. limit-1, every slice included.
  function automatic logic [63:0] chain_bytes(int unsigned limit);
    logic [63:0] sum;
    sum = 64'd0;
    for (int unsigned m = 0; m < limit; m++) begin
      sum += depth_at(m) * level_bytes(m);
    end
    return sum;
  endfunction

  function automatic offset_result_t predict_offset(logic [MIP_IN_W-1:0] mip,
                                                    logic [SLICE_W-1:0]  slice);
    offset_result_t res;
    logic [63:0]    total;
    logic [63:0]    face;
    logic [63:0]    ts;
    int unsigned    chain_len;
    int unsigned    lvl;
    logic           deep;
    chain_len = (mip_cnt > MAX_MIP_LEVELS_DEF) ? MAX_MIP_LEVELS_DEF : mip_cnt;
    deep      = depth_at(0) > 64'd1;
    if (mip[MIP_IN_W-1] != slice[SLICE_W-1]) begin
      res.offset = '0;
      res.status = ST_MIXED;
    end else begin
      if (mip[MIP_IN_W-1]) begin
        total = chain_bytes(chain_len);
        if (cube) total = total * CUBE_FACES;
      end else begin
        lvl   = (mip > MAX_MIP_LEVELS_DEF) ? MAX_MIP_LEVELS_DEF : mip;
        ts    = 64'(slice);
        total = chain_bytes(lvl);
        if (deep) total += level_bytes(lvl) * ts;
        if (cube) begin
          // Earlier faces come first, each carrying the extra slice term.
          face = chain_bytes(chain_len);
          if (deep) face += level_bytes(chain_len) * ts;
          total += face * ts;
        end
      end
      if (total > OFFSET_LIMIT) begin
        res.offset = OFFSET_MAX;
        res.status = ST_SAT;
      end else begin
        res.offset = total[OFFSET_W-1:0];
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    offset_result_t head;
    if (!rst_n) begin
      tex_w   = '0;
      tex_h   = '0;
      tex_d   = TEX_DEPTH_W'(1);
      cube    = 1'b0;
      mip_cnt = MIP_CNT_W'(1);
      blk_w   = '0;
      min_blk = MIN_BLK_W'(1);
      elem_b  = ELEM_W'(4);
      expected_offsets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEX_WIDTH:     tex_w   = cfg_data[TEX_DIM_W-1:0];
          CFG_TEX_HEIGHT:    tex_h   = cfg_data[TEX_DIM_W-1:0];
          CFG_TEX_DEPTH:     tex_d   = cfg_data[TEX_DEPTH_W-1:0];
          CFG_CUBE_MAP:      cube    = cfg_data[0];
          CFG_MIP_LEVELS:    mip_cnt = cfg_data[MIP_CNT_W-1:0];
          CFG_BLOCK_WIDTH:   blk_w   = cfg_data[BLK_W_W-1:0];
          CFG_MIN_BLOCKS:    min_blk = cfg_data[MIN_BLK_W-1:0];
          CFG_ELEMENT_BYTES: elem_b  = cfg_data[ELEM_W-1:0];
          default: ;
        endcase
      end
      // A result can never belong to a request taken at the same edge, so the
      // result side is handled first.
      if (out_valid && out_ready) begin
        if (expected_offsets.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("unexpected result: offset %h status %0d",
                     out_byte_offset, out_status);
        end else begin
          head = expected_offsets.pop_front();
          if (out_byte_offset !== head.offset || out_status !== head.status) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("mismatch: offset exp %h got %h, status exp %0d got %0d",
                       head.offset, out_byte_offset, head.status, out_status);
          end
        end
      end
      if (in_valid && in_ready)
        expected_offsets.push_back(predict_offset(in_target_mip, in_target_slice));
    end
    mismatch_count <= fail_cnt;
    pending_count  <= expected_offsets.size();
  end

endmodule

@@ tb/sv/mip_chain_offset_calc_tb.sv @@
// ----------------------------------------------------------------------------
// mip_chain_offset_calc_tb
// Drives offset requests into the mip chain offset calculator under a series
// of texture shapes and formats and lets a checker beside the block compare
// every result with its own prediction. A short directed part covers the
// field extremes, whole-size and mixed-sign requests, clamping and
// saturation; random phases with fresh settings follow.
// ----------------------------------------------------------------------------
module mip_chain_offset_calc_tb
  import mcoc_pkg::*;
();

  // Phase layout of the random part.
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 125;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES     = 800;
  // Idle cycles after the last result, before the verdict is given.
  localparam int SETTLE_CYCLES   = 300;
  // Cycles without any transfer before the run is declared hung. It has to
  // cover the long hold-off, the longest sender gap and a slow request.
  localparam int WATCHDOG_LIMIT  = 5000;

  // Receiver behavior while no hold-off is running.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index       = '0;
  logic [CFG_DATA_W-1:0]      cfg_data        = '0;
  logic                       in_valid        = 1'b0;
  logic                       in_ready;
  logic signed [MIP_IN_W-1:0] in_target_mip   = '0;
  logic signed [SLICE_W-1:0]  in_target_slice = '0;
  logic                       out_valid;
  logic                       out_ready       = 1'b0;
  logic [OFFSET_W-1:0]        out_byte_offset;
  logic [STATUS_W-1:0]        out_status;

  int mismatch_count;
  int pending_count;

  // Sender burst bookkeeping and the hold-off request to the receiver.
  int   burst_left = 1;
  logic hold_req   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mip_chain_offset_calc u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_target_mip   (in_target_mip),
    .in_target_slice (in_target_slice),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_offset (out_byte_offset),
    .out_status      (out_status)
  );

  mcoc_offset_checker u_offset_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_target_mip   (in_target_mip),
    .in_target_slice (in_target_slice),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_offset (out_byte_offset),
    .out_status      (out_status),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  // --------------------------------------------------------------------------
  // Receiver. It switches between a few stall patterns of its own, each held
  // for a random number of cycles. When the stimulus raises hold_req it stops
  // taking results through one long hold-off per raise, so that the result
  // register fills, the next request is computed, and the input side stalls
  // while the sender keeps offering.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_cnt  = 0;
  logic     hold_armed = 1'b0;
  int       rx_cycle  = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      rx_mode    <= RX_OPEN;
      mode_left  <= 0;
      hold_cnt   <= 0;
      hold_armed <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_req && !hold_armed) begin
      out_ready  <= 1'b0;
      hold_cnt   <= HOLD_CYCLES;
      hold_armed <= 1'b1;
    end else begin
      if (!hold_req) hold_armed <= 1'b0;
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
        RX_PERIODIC: out_ready <= (rx_cycle[2:0] < 3'd3);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. Any transfer on either channel restarts the count; a long run
  // of cycles with nothing moving means the block is hung.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mip_chain_offset_calc_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Writes one register and leaves the write enable high, so that a run of
  // writes never drops and raises it within one time step.
  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Writes the whole texture shape and format, in register order.
  task automatic write_setup(input int w, input int h, input int d, input int cube,
                             input int mips, input int blk, input int minb,
                             input int eb);
    write_reg(CFG_TEX_WIDTH, w);
    write_reg(CFG_TEX_HEIGHT, h);
    write_reg(CFG_TEX_DEPTH, d);
    write_reg(CFG_CUBE_MAP, cube);
    write_reg(CFG_MIP_LEVELS, mips);
    write_reg(CFG_BLOCK_WIDTH, blk);
    write_reg(CFG_MIN_BLOCKS, minb);
    write_reg(CFG_ELEMENT_BYTES, eb);
    cfg_we <= 1'b0;
  endtask

  // Random settings with the extremes and out-of-range register values mixed
  // in. Most chains are kept short since each level costs block cycles.
  task automatic write_random_setup();
    int w;
    int h;
    int d;
    int mips;
    int blk;
    int minb;
    int eb;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = 4096;
      2:       w = 8191;
      3:       w = 1;
      default: w = $urandom_range(0, 4096);
    endcase
    case ($urandom_range(0, 9))
      0:       h = 0;
      1:       h = 4096;
      2:       h = 8191;
      3:       h = $urandom_range(1, 7);
      default: h = $urandom_range(0, 4096);
    endcase
    case ($urandom_range(0, 9))
      0:       d = 0;
      1, 2:    d = 1;
      3:       d = 2048;
      4:       d = 4095;
      5, 6:    d = $urandom_range(2, 64);
      default: d = $urandom_range(0, 2048);
    endcase
    case ($urandom_range(0, 19))
      0:                  mips = $urandom_range(14, 15);
      1, 2, 3, 4, 5:      mips = $urandom_range(7, 13);
      default:            mips = $urandom_range(0, 6);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: blk = 0;
      4:          blk = $urandom_range(9, 15);
      default:    blk = $urandom_range(1, 8);
    endcase
    minb = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    eb   = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    write_setup(w, h, d, $urandom_range(0, 1), mips, blk, minb, eb);
  endtask

  // Offers one request and returns at the edge of its transfer, or after the
  // gap when a burst ends. Valid stays high across a burst; when the burst
  // ends it drops for a random gap, so gaps land on every stage of a
  // request's walk.
  task automatic send_request(input int mip, input int slice);
    int gap;
    in_valid        <= 1'b1;
    in_target_mip   <= MIP_IN_W'(mip);
    in_target_slice <= SLICE_W'(slice);
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0, 1, 2, 3:    gap = $urandom_range(1, 3);
        4, 5, 6, 7:    gap = $urandom_range(1, 12);
        8:             gap = $urandom_range(20, 120);
        default:       gap = $urandom_range(150, 300);
      endcase
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly targeted requests with small mip levels; whole-size requests, the
  // mixed-sign rejections and mip levels past the maximum make up the rest.
  task automatic send_random_request();
    int mip;
    int slice;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      mip   = -int'($urandom_range(1, 16));
      slice = $urandom_range(0, 2047);
    end else if (pick < 12) begin
      mip   = $urandom_range(0, 15);
      slice = -int'($urandom_range(1, 2048));
    end else if (pick < 24) begin
      mip   = $urandom_range(0, 1) ? -1 : -int'($urandom_range(1, 16));
      slice = $urandom_range(0, 1) ? -1 : -int'($urandom_range(1, 2048));
    end else begin
      case ($urandom_range(0, 19))
        0:                   mip = $urandom_range(14, 15);
        1, 2, 3, 4, 5, 6, 7: mip = $urandom_range(5, 13);
        default:             mip = $urandom_range(0, 4);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: slice = $urandom_range(0, 7);
        8:          slice = 2047;
        9:          slice = 0;
        default:    slice = $urandom_range(0, 2047);
      endcase
    end
    send_request(mip, slice);
  endtask

  // Drops valid and waits for every expected result. The checker's count is
  // registered, so it is first read after the next edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Largest uncompressed chain, zero depth treated as one: whole size, both
    // mip ends, a mip past the maximum, mixed signs, the most negative and
    // the largest slice values.
    write_setup(4096, 4096, 0, 0, 13, 0, 1, 16);
    send_request(-1, -1);
    send_request(0, 0);
    send_request(13, 0);
    send_request(15, 0);
    send_request(-1, 7);
    send_request(5, -1);
    send_request(-16, -2048);
    send_request(0, 2047);
    send_request(15, 2047);
    drain_results();

    // Compressed cube map with depth: width beyond the clamp, mip count past
    // the maximum, wide blocks and the widest element size. The largest
    // slice drives the sum into saturation.
    write_setup(8191, 100, 2048, 1, 15, 4, 2, 31);
    send_request(-1, -1);
    send_request(0, 0);
    send_request(13, 5);
    send_request(15, 2047);
    send_request(7, 1);
    send_request(-2, -100);
    drain_results();

    // Empty texture with no levels, zero bytes per block and no minimum.
    write_setup(0, 0, 3, 1, 0, 15, 0, 0);
    send_request(-1, -1);
    send_request(2, 3);
    send_request(-1, 0);
    send_request(0, -1);
    drain_results();

    // Whole-size request of a full-size cube that saturates.
    write_setup(4096, 4096, 2048, 1, 13, 0, 7, 16);
    send_request(-1, -1);
    send_request(1, 1);
    drain_results();

    // Random phases, each under fresh settings written while idle. Two of
    // them open with a long receiver hold-off.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_random_setup();
      if (phase == 2 || phase == 9) hold_req <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
      drain_results();
      hold_req <= 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("mip_chain_offset_calc_tb passed");
    else
      $display("mip_chain_offset_calc_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mcoc_pkg.sv
hdl/mcoc_ctrl.sv
hdl/mcoc_dp.sv
hdl/mip_chain_offset_calc.sv
tb/sv/mcoc_offset_checker.sv
tb/sv/mip_chain_offset_calc_tb.sv
